// ----- rtl/char_stream_tokenizer_unit_macros.svh -----
// Assertion macros shared by the tokenizer checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CHAR_STREAM_TOKENIZER_UNIT_MACROS_SVH
`define CHAR_STREAM_TOKENIZER_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define CST_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cst_pkg.sv -----
// Shared types, codes and character helpers for the character stream tokenizer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cst_pkg;

    // Default parameter values.
    localparam int KEYWORD_CHARS_DEF = 5;
    localparam int LENGTH_BITS_DEF   = 16;

    // Field widths and limits.
    localparam int LINE_W      = 20;
    localparam int OUT_LEN_W   = 16;
    localparam int CODE_W      = 5;
    localparam int MODE_W      = 3;
    localparam int MAX_RESULTS = 4;
    localparam int RIDX_W      = $clog2(MAX_RESULTS);
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LINE_W-1:0]    LINE_MAX    = '1;
    localparam logic [OUT_LEN_W-1:0] OUT_LEN_MAX = '1;

    // Scanner modes.
    localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDENT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STR     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COMMENT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SLASH   = 3'd5;

    // Token codes.
    localparam logic [CODE_W-1:0] TOK_IF     = 5'd0;
    localparam logic [CODE_W-1:0] TOK_LET    = 5'd1;
    localparam logic [CODE_W-1:0] TOK_PRINT  = 5'd2;
    localparam logic [CODE_W-1:0] TOK_LOOP   = 5'd3;
    localparam logic [CODE_W-1:0] TOK_BEGIN  = 5'd4;
    localparam logic [CODE_W-1:0] TOK_END    = 5'd5;
    localparam logic [CODE_W-1:0] TOK_ID     = 5'd6;
    localparam logic [CODE_W-1:0] TOK_INT    = 5'd7;
    localparam logic [CODE_W-1:0] TOK_STR    = 5'd8;
    localparam logic [CODE_W-1:0] TOK_PLUS   = 5'd9;
    localparam logic [CODE_W-1:0] TOK_MINUS  = 5'd10;
    localparam logic [CODE_W-1:0] TOK_STAR   = 5'd11;
    localparam logic [CODE_W-1:0] TOK_SLASH  = 5'd12;
    localparam logic [CODE_W-1:0] TOK_BANG   = 5'd13;
    localparam logic [CODE_W-1:0] TOK_LPAREN = 5'd14;
    localparam logic [CODE_W-1:0] TOK_RPAREN = 5'd15;
    localparam logic [CODE_W-1:0] TOK_SEMI   = 5'd16;
    localparam logic [CODE_W-1:0] TOK_ERR    = 5'd17;
    localparam logic [CODE_W-1:0] TOK_DONE   = 5'd18;
    localparam logic [CODE_W-1:0] TOK_NONE   = 5'd0;

    // Record kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Characters with a role of their own.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;

    // Keyword table, text right aligned, first character most significant.
    localparam int KW_COUNT = 6;
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h6966,          // if
        64'h6C6574,        // let
        64'h7072696E74,    // print
        64'h6C6F6F70,      // loop
        64'h626567696E,    // begin
        64'h656E64         // end
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd2, 4'd3, 4'd5, 4'd4, 4'd5, 4'd3};
    localparam logic [CODE_W-1:0] KW_CODE [KW_COUNT] = '{
        TOK_IF, TOK_LET, TOK_PRINT, TOK_LOOP, TOK_BEGIN, TOK_END
    };

    // One input beat.
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic                 record_kind;
        logic [7:0]           byte_out;
        logic [CODE_W-1:0]    token_code;
        logic [LINE_W-1:0]    line_number;
        logic [OUT_LEN_W-1:0] lexeme_length;
        logic                 last;
    } out_item_t;

    // All results of one input beat, first result in slot 0.
    typedef out_item_t [MAX_RESULTS-1:0] bundle_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Code of a one-character token; anything unknown is an error token.
    function automatic logic [CODE_W-1:0] op_code(input logic [7:0] c);
        logic [CODE_W-1:0] code;
        unique case (c)
            8'h2B:   code = TOK_PLUS;
            8'h2D:   code = TOK_MINUS;
            8'h2A:   code = TOK_STAR;
            8'h21:   code = TOK_BANG;
            8'h28:   code = TOK_LPAREN;
            8'h29:   code = TOK_RPAREN;
            8'h3B:   code = TOK_SEMI;
            default: code = TOK_ERR;
        endcase
        return code;
    endfunction

    function automatic out_item_t byte_rec(input logic [7:0] c, input logic [LINE_W-1:0] line);
        out_item_t r;
        r.record_kind   = KIND_BYTE;
        r.byte_out      = c;
        r.token_code    = TOK_NONE;
        r.line_number   = line;
        r.lexeme_length = '0;
        r.last          = 1'b0;
        return r;
    endfunction

    function automatic out_item_t end_rec(input logic [CODE_W-1:0] code,
                                          input logic [LINE_W-1:0] line,
                                          input logic [OUT_LEN_W-1:0] len);
        out_item_t r;
        r.record_kind   = KIND_END;
        r.byte_out      = '0;
        r.token_code    = code;
        r.line_number   = line;
        r.lexeme_length = len;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

// ----- rtl/cst_front.sv -----
// Front end of the tokenizer: scanner state, line counter and the first_line register.
// Classifies one byte per cycle, while accept is high, into a bundle of up to four records. Uses cst_pkg.
`timescale 1ns / 1ps

module cst_front #(
    parameter int KEYWORD_CHARS = cst_pkg::KEYWORD_CHARS_DEF,
    parameter int LENGTH_BITS   = cst_pkg::LENGTH_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  cst_pkg::in_item_t           item,
    input  logic                        cfg_we,
    input  logic [cst_pkg::LINE_W-1:0]  cfg_data,
    output logic                        enq,
    output cst_pkg::bundle_t            bundle
);

    localparam int PW = 8 * KEYWORD_CHARS;
    localparam int LW = (LENGTH_BITS > cst_pkg::OUT_LEN_W) ? LENGTH_BITS : cst_pkg::OUT_LEN_W;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic [cst_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic                       esc_reg, esc_next;
    logic [cst_pkg::LINE_W-1:0] line_reg, line_next;
    logic [LENGTH_BITS-1:0]     len_reg, len_next;
    logic [PW-1:0]              prefix_reg, prefix_next;
    logic [cst_pkg::LINE_W-1:0] first_line_reg;

    logic [cst_pkg::RCNT_W-1:0] rec_cnt;
    logic                       restart;
    logic [7:0]                 c;
    logic [7:0]                 esc_byte;
    cst_pkg::bundle_t           recs;

    // Token length as reported in an end record, saturated to the field width.
    function automatic logic [cst_pkg::OUT_LEN_W-1:0] sat_len(input logic [LENGTH_BITS-1:0] tl);
        logic [LW-1:0] w;
        w = LW'(tl);
        return (w > LW'(cst_pkg::OUT_LEN_MAX)) ? cst_pkg::OUT_LEN_MAX
                                               : w[cst_pkg::OUT_LEN_W-1:0];
    endfunction

    // Keyword match on the collected prefix; an identifier otherwise.
    function automatic logic [cst_pkg::CODE_W-1:0] word_code(input logic [PW-1:0] pre,
                                                            input logic [LENGTH_BITS-1:0] tl);
        logic [cst_pkg::CODE_W-1:0] code;
        code = cst_pkg::TOK_ID;
        for (int k = cst_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            if (int'(cst_pkg::KW_LEN[k]) <= KEYWORD_CHARS
                && tl == LENGTH_BITS'(cst_pkg::KW_LEN[k])
                && pre == PW'(cst_pkg::KW_TEXT[k]))
            begin
                code = cst_pkg::KW_CODE[k];
            end
        end
        return code;
    endfunction

    function automatic logic [cst_pkg::RIDX_W-1:0] RIDX_LAST(input logic [cst_pkg::RCNT_W-1:0] n);
        logic [cst_pkg::RCNT_W-1:0] m;
        m = n - 1'b1;
        return m[cst_pkg::RIDX_W-1:0];
    endfunction

    assign c        = item.char_in;
    assign esc_byte = (c == cst_pkg::CH_LOW_N) ? cst_pkg::CH_NL : c;

    // Scanner step: current mode first, then a fresh token start when the byte restarts.
    always_comb
    begin
        mode_next   = mode_reg;
        esc_next    = esc_reg;
        line_next   = line_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        rec_cnt     = '0;
        restart     = 1'b0;
        recs        = '0;

        if (item.end_of_input)
        begin
            // Close the open token, then send DONE and return to idle with the line counter at first_line.
            unique case (mode_reg)
                cst_pkg::MODE_IDENT:
                begin
                    recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                        cst_pkg::end_rec(word_code(prefix_next, len_next), line_next,
                                         sat_len(len_next));
                    rec_cnt = rec_cnt + 1'b1;
                end
                cst_pkg::MODE_INT:
                begin
                    recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                        cst_pkg::end_rec(cst_pkg::TOK_INT, line_next, sat_len(len_next));
                    rec_cnt = rec_cnt + 1'b1;
                end
                cst_pkg::MODE_STR:
                begin
                    recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                        cst_pkg::end_rec(cst_pkg::TOK_ERR, line_next, sat_len(len_next));
                    rec_cnt = rec_cnt + 1'b1;
                end
                cst_pkg::MODE_SLASH:
                begin
                    len_next = '0;
                    recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                        cst_pkg::byte_rec(cst_pkg::CH_SLASH, line_next);
                    rec_cnt = rec_cnt + 1'b1;
                    if (len_next != LEN_MAX)
                        len_next = len_next + 1'b1;
                    recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                        cst_pkg::end_rec(cst_pkg::TOK_SLASH, line_next, sat_len(len_next));
                    rec_cnt = rec_cnt + 1'b1;
                end
                default:
                begin
                end
            endcase
            recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                cst_pkg::end_rec(cst_pkg::TOK_DONE, line_next, '0);
            rec_cnt     = rec_cnt + 1'b1;
            mode_next   = cst_pkg::MODE_IDLE;
            esc_next    = 1'b0;
            len_next    = '0;
            prefix_next = '0;
            line_next   = first_line_reg;
        end
        else
        begin
            unique case (mode_reg)
                cst_pkg::MODE_IDENT:
                begin
                    if (cst_pkg::is_alpha(c) || cst_pkg::is_digit(c))
                    begin
                        if (len_next < LENGTH_BITS'(KEYWORD_CHARS))
                            prefix_next = {prefix_next[PW-9:0], c};
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] = cst_pkg::byte_rec(c, line_next);
                        rec_cnt = rec_cnt + 1'b1;
                        if (len_next != LEN_MAX)
                            len_next = len_next + 1'b1;
                    end
                    else
                    begin
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                            cst_pkg::end_rec(word_code(prefix_next, len_next), line_next,
                                             sat_len(len_next));
                        rec_cnt   = rec_cnt + 1'b1;
                        mode_next = cst_pkg::MODE_IDLE;
                        restart   = 1'b1;
                    end
                end
                cst_pkg::MODE_INT:
                begin
                    if (cst_pkg::is_digit(c))
                    begin
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] = cst_pkg::byte_rec(c, line_next);
                        rec_cnt = rec_cnt + 1'b1;
                        if (len_next != LEN_MAX)
                            len_next = len_next + 1'b1;
                    end
                    else
                    begin
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                            cst_pkg::end_rec(cst_pkg::TOK_INT, line_next, sat_len(len_next));
                        rec_cnt   = rec_cnt + 1'b1;
                        mode_next = cst_pkg::MODE_IDLE;
                        restart   = 1'b1;
                    end
                end
                cst_pkg::MODE_STR:
                begin
                    priority if (esc_reg)
                    begin
                        // Escaped byte: a newline counts before it is sent.
                        esc_next = 1'b0;
                        if (c == cst_pkg::CH_NL && line_next != cst_pkg::LINE_MAX)
                            line_next = line_next + 1'b1;
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                            cst_pkg::byte_rec(esc_byte, line_next);
                        rec_cnt = rec_cnt + 1'b1;
                        if (len_next != LEN_MAX)
                            len_next = len_next + 1'b1;
                    end
                    else if (c == cst_pkg::CH_BSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (c == cst_pkg::CH_QUOTE)
                    begin
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                            cst_pkg::end_rec(cst_pkg::TOK_STR, line_next, sat_len(len_next));
                        rec_cnt   = rec_cnt + 1'b1;
                        mode_next = cst_pkg::MODE_IDLE;
                    end
                    else if (c == cst_pkg::CH_NL)
                    begin
                        // Unterminated string: byte, error record, then the line counts.
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] = cst_pkg::byte_rec(c, line_next);
                        rec_cnt = rec_cnt + 1'b1;
                        if (len_next != LEN_MAX)
                            len_next = len_next + 1'b1;
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                            cst_pkg::end_rec(cst_pkg::TOK_ERR, line_next, sat_len(len_next));
                        rec_cnt = rec_cnt + 1'b1;
                        if (line_next != cst_pkg::LINE_MAX)
                            line_next = line_next + 1'b1;
                        mode_next = cst_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] = cst_pkg::byte_rec(c, line_next);
                        rec_cnt = rec_cnt + 1'b1;
                        if (len_next != LEN_MAX)
                            len_next = len_next + 1'b1;
                    end
                end
                cst_pkg::MODE_COMMENT:
                begin
                    if (c == cst_pkg::CH_NL)
                    begin
                        if (line_next != cst_pkg::LINE_MAX)
                            line_next = line_next + 1'b1;
                        mode_next = cst_pkg::MODE_IDLE;
                    end
                end
                cst_pkg::MODE_SLASH:
                begin
                    if (c == cst_pkg::CH_SLASH)
                    begin
                        mode_next = cst_pkg::MODE_COMMENT;
                    end
                    else
                    begin
                        len_next = '0;
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                            cst_pkg::byte_rec(cst_pkg::CH_SLASH, line_next);
                        rec_cnt = rec_cnt + 1'b1;
                        if (len_next != LEN_MAX)
                            len_next = len_next + 1'b1;
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                            cst_pkg::end_rec(cst_pkg::TOK_SLASH, line_next, sat_len(len_next));
                        rec_cnt   = rec_cnt + 1'b1;
                        mode_next = cst_pkg::MODE_IDLE;
                        restart   = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = cst_pkg::MODE_IDLE;
                    restart   = 1'b1;
                end
            endcase

            // Token start: the same byte opens the next token.
            if (restart)
            begin
                if (c == cst_pkg::CH_NL && line_next != cst_pkg::LINE_MAX)
                    line_next = line_next + 1'b1;
                if (!cst_pkg::is_space(c))
                begin
                    len_next    = '0;
                    prefix_next = '0;
                    esc_next    = 1'b0;
                    priority if (cst_pkg::is_alpha(c))
                    begin
                        mode_next   = cst_pkg::MODE_IDENT;
                        prefix_next = {prefix_next[PW-9:0], c};
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] = cst_pkg::byte_rec(c, line_next);
                        rec_cnt  = rec_cnt + 1'b1;
                        len_next = len_next + 1'b1;
                    end
                    else if (cst_pkg::is_digit(c))
                    begin
                        mode_next = cst_pkg::MODE_INT;
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] = cst_pkg::byte_rec(c, line_next);
                        rec_cnt  = rec_cnt + 1'b1;
                        len_next = len_next + 1'b1;
                    end
                    else if (c == cst_pkg::CH_QUOTE)
                    begin
                        mode_next = cst_pkg::MODE_STR;
                    end
                    else if (c == cst_pkg::CH_SLASH)
                    begin
                        mode_next = cst_pkg::MODE_SLASH;
                    end
                    else
                    begin
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] = cst_pkg::byte_rec(c, line_next);
                        rec_cnt  = rec_cnt + 1'b1;
                        len_next = len_next + 1'b1;
                        recs[rec_cnt[cst_pkg::RIDX_W-1:0]] =
                            cst_pkg::end_rec(cst_pkg::op_code(c), line_next, sat_len(len_next));
                        rec_cnt   = rec_cnt + 1'b1;
                        mode_next = cst_pkg::MODE_IDLE;
                    end
                end
            end
        end

        // Mark the final record of this beat.
        if (rec_cnt != '0)
            recs[RIDX_LAST(rec_cnt)].last = 1'b1;
    end

    assign enq    = accept && (rec_cnt != '0);
    assign bundle = recs;

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= cst_pkg::MODE_IDLE;
            esc_reg    <= 1'b0;
            line_reg   <= '0;
            len_reg    <= '0;
            prefix_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            esc_reg    <= esc_next;
            line_reg   <= line_next;
            len_reg    <= len_next;
            prefix_reg <= prefix_next;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_line_reg <= '0;
        end
        else if (cfg_we)
        begin
            first_line_reg <= cfg_data;
        end
    end

endmodule

// ----- rtl/cst_queue.sv -----
// Short bundle queue between the tokenizer front and back.
// Holds whole result bundles so that each side stalls on its own. Uses cst_pkg.
`timescale 1ns / 1ps

module cst_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enq,
    input  cst_pkg::bundle_t    enq_data,
    input  logic                deq,
    output cst_pkg::bundle_t    head,
    output cst_pkg::q_status_t  status
);

    cst_pkg::bundle_t             slot_reg [cst_pkg::QUEUE_DEPTH];
    logic [cst_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [cst_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [cst_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         do_enq;
    logic                         do_deq;

    function automatic logic [cst_pkg::QPTR_W-1:0] ptr_inc(input logic [cst_pkg::QPTR_W-1:0] p);
        return (p == cst_pkg::QPTR_W'(cst_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign status.full  = (count_reg == cst_pkg::QCNT_W'(cst_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_enq       = enq && !status.full;
    assign do_deq       = deq && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_enq ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_deq ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_enq && !do_deq)
            count_next = count_reg + 1'b1;
        else if (!do_enq && do_deq)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Bundle storage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (do_enq)
            slot_reg[wr_ptr_reg] <= enq_data;
    end

endmodule

// ----- rtl/cst_back.sv -----
// Back end of the tokenizer: walks the head bundle one record per beat.
// Releases the bundle after its final record is taken. Uses cst_pkg.
`timescale 1ns / 1ps

module cst_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cst_pkg::bundle_t    head,
    input  cst_pkg::q_status_t  status,
    input  logic                pop,
    output logic                deq,
    output logic                empty,
    output cst_pkg::out_item_t  result
);

    logic [cst_pkg::RIDX_W-1:0] sub_reg, sub_next;
    logic                       take;

    assign empty  = status.empty;
    assign result = head[sub_reg];
    assign take   = pop && !status.empty;
    assign deq    = take && result.last;

    // Record index within the head bundle.
    always_comb
    begin
        sub_next = sub_reg;
        if (take)
            sub_next = result.last ? '0 : sub_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sub_reg <= '0;
        end else begin
            sub_reg <= sub_next;
        end
    end

endmodule

// ----- rtl/char_stream_tokenizer_unit.sv -----
// Character stream tokenizer, top level.
// Channels: push/full takes one input beat (char_in, end_of_input) per cycle; an
// input beat is taken when push is high and full is low. Results leave through
// empty/pop: the oldest record sits on result while empty is low and is taken
// when pop is high. Each input beat yields zero to four records: lexeme bytes
// and token-end records, the final one of a beat flagged by last.
// cfg_valid/cfg_ready/cfg_data write first_line; cfg_ready is always high, and
// the value is loaded into the line counter at end of input.
// The records of a beat are registered in the queue before they reach result.
// Throughput: one input beat per cycle while the four-bundle queue has room; the
// result side delivers one record per cycle while pop is high, so beats with several
// records drain at that rate and the queue fills when the receiver falls behind.
// Stalls: while pop is low, records wait in the queue and full rises once four
// bundles are held; input beats that yield no record are still not taken then.
// Reset (rst_n low, asynchronous): the queue empties, the scanner goes idle and the
// line counter and first_line return to zero.
`timescale 1ns / 1ps

module char_stream_tokenizer_unit #(
    parameter int KEYWORD_CHARS = cst_pkg::KEYWORD_CHARS_DEF,
    parameter int LENGTH_BITS   = cst_pkg::LENGTH_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  cst_pkg::in_item_t           item,
    output logic                        empty,
    input  logic                        pop,
    output cst_pkg::out_item_t          result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cst_pkg::LINE_W-1:0]  cfg_data
);

    cst_pkg::bundle_t   bundle;
    cst_pkg::bundle_t   head;
    cst_pkg::q_status_t q_status;
    logic               accept;
    logic               enq;
    logic               deq;

    assign cfg_ready = 1'b1;
    assign full      = q_status.full;
    assign accept    = push && !q_status.full;

    // Scanner and classifier.
    cst_front #(
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .enq      (enq),
        .bundle   (bundle)
    );

    // Bundle queue.
    cst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (enq),
        .enq_data (bundle),
        .deq      (deq),
        .head     (head),
        .status   (q_status)
    );

    // Record serializer.
    cst_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .status (q_status),
        .pop    (pop),
        .deq    (deq),
        .empty  (empty),
        .result (result)
    );

endmodule

// ----- rtl/cst_checker.sv -----
// Port-level checker for the character stream tokenizer, bound to the top level.
// Depends on cst_pkg and char_stream_tokenizer_unit_macros.svh.
`timescale 1ns / 1ps
`include "char_stream_tokenizer_unit_macros.svh"

module cst_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        empty,
    input logic                        pop,
    input cst_pkg::out_item_t          result
);

    // Nothing is waiting once reset has been sampled low.
    `CST_ASSERT_ALWAYS(a_empty_after_reset, clk, !rst_n |=> empty, "results present after reset")

    // A waiting result is held until it is taken.
    `CST_ASSERT(a_hold_stalled, clk, rst_n, !empty && !pop |=> !empty && $stable(result), "stalled result changed")

    // DONE always closes the records of its input beat.
    `CST_ASSERT(a_done_last, clk, rst_n, !empty && result.record_kind == cst_pkg::KIND_END && result.token_code == cst_pkg::TOK_DONE |-> result.last, "DONE not last")

    // Lexeme byte records carry no code and no length.
    `CST_ASSERT(a_byte_fields, clk, rst_n, !empty && result.record_kind == cst_pkg::KIND_BYTE |-> result.token_code == cst_pkg::TOK_NONE && result.lexeme_length == '0, "byte record fields set")

endmodule

bind char_stream_tokenizer_unit cst_checker u_cst_checker (.*);

// ----- sim/char_stream_tokenizer_unit_checker.sv -----
// Scoreboard for the character stream tokenizer: watches the input, result and
// first_line channels, predicts every record and compares it with the block's output.
// Depends on cst_pkg for the beat types, token codes and scanner modes.
`timescale 1ns / 1ps

module char_stream_tokenizer_unit_checker #(
    parameter int KEYWORD_CHARS = cst_pkg::KEYWORD_CHARS_DEF,
    parameter int LENGTH_BITS   = cst_pkg::LENGTH_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        full,
    input  cst_pkg::in_item_t           item,
    input  logic                        empty,
    input  logic                        pop,
    input  cst_pkg::out_item_t          result,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [cst_pkg::LINE_W-1:0]  cfg_data,
    output int                          fail_count,
    output int                          outstanding,
    output int                          beats_seen,
    output int                          records_seen,
    output logic [31:0]                 codes_seen
);

    import cst_pkg::*;

    localparam int REPORT_LIMIT = 10;
    localparam longint unsigned LEN_CAP = (64'd1 << LENGTH_BITS) - 1;

    // Keywords packed one byte per character, first character most significant.
    localparam int WORD_COUNT = 6;
    localparam logic [63:0] KEYWORD_WORDS [WORD_COUNT] = '{
        "if", "let", "print", "loop", "begin", "end"
    };
    localparam int KEYWORD_SIZES [WORD_COUNT] = '{2, 3, 5, 4, 5, 3};
    localparam logic [CODE_W-1:0] KEYWORD_TOKENS [WORD_COUNT] = '{
        TOK_IF, TOK_LET, TOK_PRINT, TOK_LOOP, TOK_BEGIN, TOK_END
    };

    // Scanner state as the predictor sees it.
    logic [MODE_W-1:0] scan_state;
    logic              in_escape;
    logic [LINE_W-1:0] line_cnt;
    logic [LINE_W-1:0] line_base;
    longint unsigned   lex_len;
    logic [63:0]       word_head;

    // Records of the beat being predicted, then the queue of records still owed.
    out_item_t beat_recs [MAX_RESULTS];
    int        beat_nrec;
    out_item_t owed_records [$];

    int mismatches;
    int beat_total;
    int record_total;
    logic [31:0] code_mask;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [CODE_W-1:0] single_char_code(input logic [7:0] c);
        case (c)
            "+":     return TOK_PLUS;
            "-":     return TOK_MINUS;
            "*":     return TOK_STAR;
            "!":     return TOK_BANG;
            "(":     return TOK_LPAREN;
            ")":     return TOK_RPAREN;
            ";":     return TOK_SEMI;
            default: return TOK_ERR;
        endcase
    endfunction

    // A beat never yields more than four records; any further one is dropped.
    function automatic void add_record(input logic kind, input logic [7:0] b,
                                       input logic [CODE_W-1:0] code,
                                       input logic [LINE_W-1:0] line,
                                       input logic [OUT_LEN_W-1:0] len);
        out_item_t r;
        r.record_kind   = kind;
        r.byte_out      = b;
        r.token_code    = code;
        r.line_number   = line;
        r.lexeme_length = len;
        r.last          = 1'b0;
        if (beat_nrec < MAX_RESULTS)
        begin
            beat_recs[beat_nrec] = r;
            beat_nrec++;
        end
    endfunction

    function automatic void bump_line();
        if (line_cnt != LINE_MAX)
            line_cnt++;
    endfunction

    function automatic void emit_lexeme(input logic [7:0] c);
        add_record(KIND_BYTE, c, TOK_NONE, line_cnt, '0);
        if (lex_len < LEN_CAP)
            lex_len++;
    endfunction

    function automatic void close_token(input logic [CODE_W-1:0] code,
                                        input logic [LINE_W-1:0] line);
        logic [OUT_LEN_W-1:0] len;
        len = (lex_len > OUT_LEN_MAX) ? OUT_LEN_MAX : lex_len[OUT_LEN_W-1:0];
        add_record(KIND_END, '0, code, line, len);
    endfunction

    // Only the leading bytes of a word are kept for keyword matching.
    function automatic void word_lexeme(input logic [7:0] c);
        if (lex_len < KEYWORD_CHARS)
            word_head = {word_head[55:0], c};
        emit_lexeme(c);
    endfunction

    function automatic void close_word();
        logic [CODE_W-1:0] code;
        code = TOK_ID;
        for (int k = WORD_COUNT - 1; k >= 0; k--)
        begin
            if (KEYWORD_SIZES[k] == lex_len && KEYWORD_SIZES[k] <= KEYWORD_CHARS &&
                KEYWORD_WORDS[k] == word_head)
                code = KEYWORD_TOKENS[k];
        end
        close_token(code, line_cnt);
    endfunction

    // First byte of a token, seen from the idle state.
    function automatic void start_token(input logic [7:0] c);
        if (c == CH_NL)
            bump_line();
        if (!is_blank(c))
        begin
            lex_len   = 0;
            word_head = '0;
            in_escape = 1'b0;
            if (is_letter(c))
            begin
                scan_state = MODE_IDENT;
                word_lexeme(c);
            end
            else if (is_numeral(c))
            begin
                scan_state = MODE_INT;
                emit_lexeme(c);
            end
            else if (c == CH_QUOTE)
                scan_state = MODE_STR;
            else if (c == CH_SLASH)
                scan_state = MODE_SLASH;
            else
            begin
                emit_lexeme(c);
                close_token(single_char_code(c), line_cnt);
                scan_state = MODE_IDLE;
            end
        end
    endfunction

    function automatic void step_char(input logic [7:0] c);
        case (scan_state)
            MODE_IDENT:
            begin
                if (is_letter(c) || is_numeral(c))
                    word_lexeme(c);
                else
                begin
                    close_word();
                    scan_state = MODE_IDLE;
                    start_token(c);
                end
            end
            MODE_INT:
            begin
                if (is_numeral(c))
                    emit_lexeme(c);
                else
                begin
                    close_token(TOK_INT, line_cnt);
                    scan_state = MODE_IDLE;
                    start_token(c);
                end
            end
            MODE_STR:
            begin
                if (in_escape)
                begin
                    in_escape = 1'b0;
                    if (c == CH_NL)
                        bump_line();
                    emit_lexeme((c == CH_LOW_N) ? CH_NL : c);
                end
                else if (c == CH_BSLASH)
                    in_escape = 1'b1;
                else if (c == CH_QUOTE)
                begin
                    close_token(TOK_STR, line_cnt);
                    scan_state = MODE_IDLE;
                end
                else if (c == CH_NL)
                begin
                    // The error record carries the line before the newline.
                    emit_lexeme(c);
                    close_token(TOK_ERR, line_cnt);
                    bump_line();
                    scan_state = MODE_IDLE;
                end
                else
                    emit_lexeme(c);
            end
            MODE_COMMENT:
            begin
                if (c == CH_NL)
                begin
                    bump_line();
                    scan_state = MODE_IDLE;
                end
            end
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                    scan_state = MODE_COMMENT;
                else
                begin
                    lex_len = 0;
                    emit_lexeme(CH_SLASH);
                    close_token(TOK_SLASH, line_cnt);
                    scan_state = MODE_IDLE;
                    start_token(c);
                end
            end
            default:
            begin
                scan_state = MODE_IDLE;
                start_token(c);
            end
        endcase
    endfunction

    // End of input completes the open token, sends DONE and starts over.
    function automatic void step_end();
        case (scan_state)
            MODE_IDENT: close_word();
            MODE_INT:   close_token(TOK_INT, line_cnt);
            MODE_STR:   close_token(TOK_ERR, line_cnt);
            MODE_SLASH:
            begin
                lex_len = 0;
                emit_lexeme(CH_SLASH);
                close_token(TOK_SLASH, line_cnt);
            end
            default: ;
        endcase
        add_record(KIND_END, '0, TOK_DONE, line_cnt, '0);
        scan_state = MODE_IDLE;
        in_escape  = 1'b0;
        lex_len    = 0;
        word_head  = '0;
        line_cnt   = line_base;
    endfunction

    function automatic void predict_beat(input in_item_t beat);
        beat_nrec = 0;
        if (beat.end_of_input)
            step_end();
        else
            step_char(beat.char_in);
        if (beat_nrec > 0)
            beat_recs[beat_nrec - 1].last = 1'b1;
        for (int i = 0; i < beat_nrec; i++)
            owed_records.push_back(beat_recs[i]);
    endfunction

    // Channel monitor: all handshakes are sampled on the rising edge.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t want;
        if (!rst_n)
        begin
            scan_state   = MODE_IDLE;
            in_escape    = 1'b0;
            line_cnt     = '0;
            line_base    = '0;
            lex_len      = 0;
            word_head    = '0;
            mismatches   = 0;
            beat_total   = 0;
            record_total = 0;
            code_mask    = '0;
            owed_records.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                line_base = cfg_data;

            if (push && !full)
            begin
                predict_beat(item);
                beat_total++;
            end

            if (pop && !empty)
            begin
                record_total++;
                if (owed_records.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("[%0t] record %0d arrived with nothing expected: kind=%0d byte=%02h code=%0d line=%0d len=%0d last=%0d",
                                 $realtime, record_total, result.record_kind, result.byte_out,
                                 result.token_code, result.line_number, result.lexeme_length,
                                 result.last);
                    mismatches++;
                end
                else
                begin
                    want = owed_records.pop_front();
                    if (want.record_kind == KIND_END)
                        code_mask[want.token_code] = 1'b1;
                    if (result.record_kind   !== want.record_kind   ||
                        result.byte_out      !== want.byte_out      ||
                        result.token_code    !== want.token_code    ||
                        result.line_number   !== want.line_number   ||
                        result.lexeme_length !== want.lexeme_length ||
                        result.last          !== want.last)
                    begin
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $display("[%0t] record %0d expected kind=%0d byte=%02h code=%0d line=%0d len=%0d last=%0d",
                                     $realtime, record_total, want.record_kind, want.byte_out,
                                     want.token_code, want.line_number, want.lexeme_length,
                                     want.last);
                            $display("[%0t] record %0d actual   kind=%0d byte=%02h code=%0d line=%0d len=%0d last=%0d",
                                     $realtime, record_total, result.record_kind, result.byte_out,
                                     result.token_code, result.line_number, result.lexeme_length,
                                     result.last);
                        end
                        mismatches++;
                    end
                end
            end
        end

        fail_count   <= mismatches;
        outstanding  <= owed_records.size();
        beats_seen   <= beat_total;
        records_seen <= record_total;
        codes_seen   <= code_mask;
    end

endmodule

// ----- sim/char_stream_tokenizer_unit_tb.sv -----
// Testbench top for the character stream tokenizer: drives token streams and
// first_line settings, and gives the verdict from the scoreboard's failure and outstanding counts.
// Depends on cst_pkg, char_stream_tokenizer_unit and char_stream_tokenizer_unit_checker.
`timescale 1ns / 1ps

module char_stream_tokenizer_unit_tb;

    import cst_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASE_BEATS    = 50;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                push      = 1'b0;
    logic                full;
    in_item_t            item      = '0;
    logic                empty;
    logic                pop       = 1'b0;
    out_item_t           result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LINE_W-1:0]   cfg_data  = '0;

    int          fail_count;
    int          outstanding;
    int          beats_seen;
    int          records_seen;
    logic [31:0] codes_seen;

    int quiet_cycles  = 0;
    int push_stretch  = 0;
    int pop_stretch   = 0;
    int counted_beats = 0;
    int cfg_writes    = 0;

    string KEYWORD_LIST [6] = '{"if", "let", "print", "loop", "begin", "end"};
    string OPERATORS = "+-*/!();";
    string ALNUM = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

    always #5 clk = ~clk;

    char_stream_tokenizer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    char_stream_tokenizer_unit_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .item         (item),
        .empty        (empty),
        .pop          (pop),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .beats_seen   (beats_seen),
        .records_seen (records_seen),
        .codes_seen   (codes_seen)
    );

    // Idle cycles before the next beat; now and then a run of back-to-back beats.
    function automatic int draw_gap(inout int stretch);
        if (stretch > 0)
        begin
            stretch--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            stretch = $urandom_range(10, 30);
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [7:0] alnum_char();
        return ALNUM[$urandom_range(0, ALNUM.len() - 1)];
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(8, 14);
        return (r < 9 || r > 13) ? 8'h20 : 8'(r);
    endfunction

    // One input beat; push stays high until the block takes it.
    task automatic push_beat(input logic [7:0] c, input logic eoi, input bit counted);
        int gap;
        gap = draw_gap(push_stretch);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= '{char_in: c, end_of_input: eoi};
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (counted)
            counted_beats++;
    endtask

    task automatic send_text(input string s, input bit counted);
        for (int i = 0; i < s.len(); i++)
            push_beat(s[i], 1'b0, counted);
    endtask

    // Stop sending and wait until every owed record has been taken.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_first_line(input logic [LINE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // One random token, mostly well formed, with occasional noise.
    task automatic send_random_token();
        int pick;
        int n;
        bit word_like;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        word_like = 1'b0;
        if (pick < 15)
        begin
            send_text(KEYWORD_LIST[$urandom_range(0, 5)], 1'b1);
            if ($urandom_range(0, 2) == 0)
                push_beat(alnum_char(), 1'b0, 1'b1);
            word_like = 1'b1;
        end
        else if (pick < 30)
        begin
            n = $urandom_range(0, 7);
            push_beat(ALNUM[$urandom_range(0, 51)], 1'b0, 1'b1);
            repeat (n) push_beat(alnum_char(), 1'b0, 1'b1);
            word_like = 1'b1;
        end
        else if (pick < 42)
        begin
            n = $urandom_range(1, 6);
            repeat (n) push_beat(8'("0" + $urandom_range(0, 9)), 1'b0, 1'b1);
            word_like = 1'b1;
        end
        else if (pick < 57)
        begin
            // Quoted string with escapes; sometimes broken by a bare newline or left open.
            push_beat(CH_QUOTE, 1'b0, 1'b1);
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                case ($urandom_range(0, 7))
                    0: push_beat(8'($urandom_range(128, 255)), 1'b0, 1'b1);
                    1, 2:
                    begin
                        push_beat(CH_BSLASH, 1'b0, 1'b1);
                        case ($urandom_range(0, 4))
                            0:       push_beat(CH_LOW_N, 1'b0, 1'b1);
                            1:       push_beat(CH_QUOTE, 1'b0, 1'b1);
                            2:       push_beat(CH_BSLASH, 1'b0, 1'b1);
                            3:       push_beat(CH_NL, 1'b0, 1'b1);
                            default: push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                        endcase
                    end
                    default:
                    begin
                        c = 8'($urandom_range(32, 126));
                        if (c == CH_QUOTE || c == CH_BSLASH)
                            c = "x";
                        push_beat(c, 1'b0, 1'b1);
                    end
                endcase
            end
            n = $urandom_range(0, 19);
            if (n < 17)
                push_beat(CH_QUOTE, 1'b0, 1'b1);
            else if (n < 19)
                push_beat(CH_NL, 1'b0, 1'b1);
        end
        else if (pick < 72)
            push_beat(OPERATORS[$urandom_range(0, 7)], 1'b0, 1'b1);
        else if (pick < 78)
        begin
            push_beat(CH_SLASH, 1'b0, 1'b1);
            push_beat(CH_SLASH, 1'b0, 1'b1);
            n = $urandom_range(0, 8);
            repeat (n)
            begin
                c = 8'($urandom_range(0, 255));
                push_beat((c == CH_NL) ? 8'h20 : c, 1'b0, 1'b0);
            end
            if ($urandom_range(0, 9) != 0)
                push_beat(CH_NL, 1'b0, 1'b0);
        end
        else if (pick < 88)
            push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        else if (pick < 96)
        begin
            n = $urandom_range(1, 3);
            repeat (n) push_beat(blank_char(), 1'b0, 1'b0);
        end
        else
            push_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);

        // Words and numbers are usually followed by blank space, else by the next token.
        if (word_like && $urandom_range(0, 9) < 7)
            push_beat(blank_char(), 1'b0, 1'b0);
    endtask

    task automatic run_random_phase(input int goal);
        counted_beats = 0;
        while (counted_beats < goal)
            send_random_token();
        push_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    // Receiver: pops with random pauses between records.
    initial
    begin : receiver
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(pop_stretch);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    // Watchdog: counts cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[%0t] no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("char_stream_tokenizer_unit verification failed");
        $finish;
    end

    // Main sequence.
    initial
    begin : stimulus
        logic [LINE_W-1:0] phase_base [4];
        phase_base[0] = LINE_MAX;
        phase_base[1] = '0;
        phase_base[2] = LINE_W'($urandom_range(0, 1048575));
        phase_base[3] = LINE_W'($urandom_range(0, 1048575));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Just below the line limit; loaded at the next end of input, so first-phase newlines saturate.
        write_first_line(LINE_MAX - 2);

        // Directed: extreme bytes, a word cut by an operator, slash followed by another
        // token, a comment, a string with n, quote and newline escapes and a bare newline, then
        // a number and a pending slash closed by end of input.
        push_beat(8'h00, 1'b0, 1'b1);
        push_beat(8'hFF, 1'b0, 1'b1);
        send_text("ab1+/;//x\n\"\\n\\\"\\\n\n7 /", 1'b1);
        push_beat(8'hA5, 1'b1, 1'b1);

        // Random phases; the first_line written before each one is loaded at its final end of input.
        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            write_first_line(phase_base[p]);
            run_random_phase(PHASE_BEATS);
        end

        wait_drained();

        $display("Run covered %0d input beats and %0d checked records under %0d first_line settings.",
                 beats_seen, records_seen, cfg_writes);
        $display("End records carried %0d of %0d token codes; %0d mismatches.",
                 $countones(codes_seen), TOK_DONE + 1, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("char_stream_tokenizer_unit verification clean");
        else
            $display("char_stream_tokenizer_unit verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_front.sv
rtl/cst_queue.sv
rtl/cst_back.sv
rtl/char_stream_tokenizer_unit.sv
rtl/cst_checker.sv
sim/char_stream_tokenizer_unit_checker.sv
sim/char_stream_tokenizer_unit_tb.sv
